// ===== hdl/rc40_pkg.sv =====
`default_nettype none

package rc40_pkg;

	// Alphabet size and default configuration.
	localparam int unsigned NSYM            = 40;
	localparam int unsigned MAX_ROTORS_DEF  = 8;
	localparam logic [3:0]  COUNT_RESET     = 4'd8;
	localparam logic [31:0] SELECT_RESET    = 32'h7654_3210;

	// Configuration register indexes.
	localparam logic CFG_ROTOR_COUNT  = 1'b0;
	localparam logic CFG_ROTOR_SELECT = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ILLEGAL  = 2'd1;
	localparam logic [1:0] ST_BAD_SLOT = 2'd2;

	// Input command kinds.
	localparam logic FUNC_CIPHER = 1'b0;
	localparam logic FUNC_SET    = 1'b1;

	// Rotor wirings, one row per wiring number.
	localparam logic [5:0] WIRING [0:9][0:39] = '{
		'{6'd36,6'd23,6'd18,6'd17,6'd22,6'd13,6'd3,6'd30,6'd2,6'd11,6'd0,6'd32,6'd31,6'd27,
		  6'd1,6'd6,6'd10,6'd29,6'd26,6'd15,6'd28,6'd24,6'd33,6'd34,6'd16,6'd21,6'd8,6'd38,
		  6'd20,6'd35,6'd7,6'd39,6'd25,6'd19,6'd9,6'd14,6'd4,6'd5,6'd37,6'd12},
		'{6'd9,6'd26,6'd18,6'd16,6'd32,6'd39,6'd13,6'd24,6'd37,6'd1,6'd33,6'd10,6'd21,6'd20,
		  6'd14,6'd3,6'd11,6'd31,6'd29,6'd4,6'd0,6'd28,6'd22,6'd17,6'd38,6'd27,6'd8,6'd6,
		  6'd2,6'd19,6'd36,6'd5,6'd25,6'd35,6'd15,6'd23,6'd7,6'd12,6'd30,6'd34},
		'{6'd4,6'd28,6'd36,6'd7,6'd11,6'd33,6'd37,6'd5,6'd32,6'd15,6'd19,6'd35,6'd6,6'd10,
		  6'd22,6'd26,6'd3,6'd18,6'd38,6'd1,6'd30,6'd21,6'd31,6'd34,6'd9,6'd13,6'd14,6'd39,
		  6'd27,6'd0,6'd24,6'd20,6'd12,6'd17,6'd23,6'd29,6'd8,6'd2,6'd25,6'd16},
		'{6'd38,6'd15,6'd30,6'd20,6'd18,6'd10,6'd36,6'd17,6'd35,6'd11,6'd5,6'd25,6'd34,6'd12,
		  6'd31,6'd7,6'd37,6'd32,6'd22,6'd14,6'd19,6'd26,6'd24,6'd1,6'd33,6'd6,6'd16,6'd29,
		  6'd4,6'd0,6'd8,6'd28,6'd2,6'd13,6'd9,6'd27,6'd23,6'd39,6'd21,6'd3},
		'{6'd30,6'd22,6'd11,6'd28,6'd6,6'd17,6'd14,6'd15,6'd24,6'd25,6'd35,6'd2,6'd10,6'd12,
		  6'd31,6'd18,6'd5,6'd1,6'd0,6'd8,6'd3,6'd7,6'd39,6'd4,6'd20,6'd21,6'd33,6'd19,
		  6'd36,6'd37,6'd27,6'd29,6'd23,6'd13,6'd26,6'd38,6'd34,6'd32,6'd9,6'd16},
		'{6'd8,6'd27,6'd13,6'd34,6'd11,6'd6,6'd4,6'd25,6'd35,6'd28,6'd29,6'd14,6'd5,6'd33,
		  6'd7,6'd10,6'd15,6'd17,6'd9,6'd24,6'd38,6'd23,6'd31,6'd0,6'd39,6'd22,6'd32,6'd21,
		  6'd12,6'd36,6'd20,6'd30,6'd1,6'd2,6'd3,6'd16,6'd37,6'd26,6'd19,6'd18},
		'{6'd35,6'd15,6'd24,6'd13,6'd17,6'd38,6'd31,6'd29,6'd34,6'd18,6'd11,6'd5,6'd27,6'd7,
		  6'd21,6'd20,6'd9,6'd1,6'd8,6'd14,6'd19,6'd22,6'd6,6'd32,6'd4,6'd16,6'd33,6'd36,
		  6'd26,6'd23,6'd2,6'd10,6'd25,6'd30,6'd0,6'd39,6'd3,6'd12,6'd28,6'd37},
		'{6'd4,6'd14,6'd27,6'd6,6'd16,6'd3,6'd36,6'd25,6'd29,6'd2,6'd33,6'd21,6'd0,6'd39,
		  6'd13,6'd35,6'd37,6'd5,6'd17,6'd19,6'd30,6'd23,6'd18,6'd34,6'd8,6'd38,6'd22,6'd12,
		  6'd20,6'd9,6'd26,6'd24,6'd7,6'd11,6'd31,6'd1,6'd28,6'd32,6'd10,6'd15},
		'{6'd32,6'd33,6'd36,6'd21,6'd1,6'd11,6'd22,6'd17,6'd31,6'd3,6'd39,6'd2,6'd15,6'd29,
		  6'd25,6'd34,6'd8,6'd18,6'd37,6'd4,6'd7,6'd0,6'd30,6'd5,6'd10,6'd12,6'd26,6'd9,
		  6'd35,6'd24,6'd23,6'd38,6'd19,6'd28,6'd6,6'd16,6'd14,6'd27,6'd20,6'd13},
		'{6'd5,6'd19,6'd13,6'd18,6'd14,6'd28,6'd38,6'd4,6'd3,6'd20,6'd29,6'd2,6'd39,6'd25,
		  6'd24,6'd30,6'd12,6'd1,6'd11,6'd36,6'd35,6'd32,6'd0,6'd34,6'd33,6'd7,6'd23,6'd8,
		  6'd22,6'd10,6'd16,6'd37,6'd26,6'd31,6'd15,6'd27,6'd6,6'd21,6'd9,6'd17}
	};

	localparam logic [5:0] NOTCH [0:9] = '{
		6'd39,6'd0,6'd10,6'd19,6'd26,6'd14,6'd6,6'd39,6'd33,6'd5
	};

	localparam logic [5:0] REFLECTOR [0:39] = '{
		6'd28,6'd34,6'd20,6'd7,6'd38,6'd17,6'd23,6'd3,6'd11,6'd15,6'd27,6'd8,6'd22,6'd24,
		6'd32,6'd9,6'd21,6'd5,6'd29,6'd39,6'd2,6'd16,6'd12,6'd6,6'd13,6'd30,6'd37,6'd10,
		6'd0,6'd18,6'd25,6'd33,6'd14,6'd31,6'd1,6'd36,6'd35,6'd26,6'd4,6'd19
	};

	// Datapath operations of one microcode step.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,      // t = symbol code of the latched character
		OP_ADDP,      // t = t + pos[idx]
		OP_FWDSUB,    // t = wiring(idx)[t] - pos[idx]
		OP_INVSUB,    // t = inverse wiring(idx)[t] - pos[idx]
		OP_FWDREF,    // t = reflector[wiring(idx)[t]]
		OP_CHK,       // carry = notch of slot idx+1 matches pos[idx+1]
		OP_STEP,      // pos[idx] = pos[idx] + 1
		OP_WRP,       // pos[idx] = new position
		OP_RES_OK,    // result = enciphered character, status ok
		OP_RES_ZERO,  // result = 0, status ok
		OP_RES_ILL,   // result = 0, illegal character
		OP_RES_BAD    // result = 0, slot out of range
	} op_t;

	// Slot index update, applied at the end of the step.
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_CLR,
		IDX_INC,
		IDX_DEC,
		IDX_LAST,
		IDX_SLOT
	} idx_act_t;

	// Jump conditions.
	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_SET,
		C_ILLEGAL,
		C_LAST,
		C_NOTLAST,
		C_ZERO,
		C_NOTZERO,
		C_GO,
		C_BADSLOT,
		C_SETMID
	} cond_t;

	localparam int unsigned PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		op_t      op;
		idx_act_t idx_act;
		cond_t    cond;
		pc_t      target;
		logic     wait_in;
		logic     emit;
	} ctrl_t;

	// Program labels.
	localparam pc_t P_IDLE  = 5'd0;
	localparam pc_t P_DISP  = 5'd1;
	localparam pc_t P_FL    = 5'd6;
	localparam pc_t P_FEND  = 5'd8;
	localparam pc_t P_BL    = 5'd10;
	localparam pc_t P_BEND  = 5'd12;
	localparam pc_t P_SL    = 5'd14;
	localparam pc_t P_SLAST = 5'd17;
	localparam pc_t P_EMIT  = 5'd19;
	localparam pc_t P_ILL   = 5'd20;
	localparam pc_t P_SET   = 5'd21;
	localparam pc_t P_SMID  = 5'd26;
	localparam pc_t P_BAD   = 5'd28;

	function automatic ctrl_t mk(input op_t op, input idx_act_t ia, input cond_t c,
	                             input pc_t tgt);
		ctrl_t w;
		w.op      = op;
		w.idx_act = ia;
		w.cond    = c;
		w.target  = tgt;
		w.wait_in = 1'b0;
		w.emit    = 1'b0;
		return w;
	endfunction

	// Microcode program.
	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		unique case (pc)
			5'd0: begin
				w = mk(OP_NOP, IDX_CLR, C_NONE, P_IDLE);
				w.wait_in = 1'b1;
			end
			5'd1:  w = mk(OP_NOP,      IDX_HOLD, C_SET,     P_SET);
			5'd2:  w = mk(OP_NOP,      IDX_HOLD, C_ILLEGAL, P_ILL);
			5'd3:  w = mk(OP_LOAD,     IDX_HOLD, C_NONE,    P_IDLE);
			5'd4:  w = mk(OP_ADDP,     IDX_HOLD, C_NONE,    P_IDLE);
			5'd5:  w = mk(OP_NOP,      IDX_HOLD, C_LAST,    P_FEND);
			5'd6:  w = mk(OP_FWDSUB,   IDX_INC,  C_NONE,    P_IDLE);
			5'd7:  w = mk(OP_ADDP,     IDX_HOLD, C_NOTLAST, P_FL);
			5'd8:  w = mk(OP_FWDREF,   IDX_HOLD, C_NONE,    P_IDLE);
			5'd9:  w = mk(OP_NOP,      IDX_HOLD, C_ZERO,    P_BEND);
			5'd10: w = mk(OP_INVSUB,   IDX_DEC,  C_NONE,    P_IDLE);
			5'd11: w = mk(OP_ADDP,     IDX_HOLD, C_NOTZERO, P_BL);
			5'd12: w = mk(OP_INVSUB,   IDX_HOLD, C_NONE,    P_IDLE);
			5'd13: w = mk(OP_RES_OK,   IDX_CLR,  C_NONE,    P_IDLE);
			5'd14: w = mk(OP_CHK,      IDX_HOLD, C_LAST,    P_SLAST);
			5'd15: w = mk(OP_STEP,     IDX_INC,  C_GO,      P_SL);
			5'd16: w = mk(OP_NOP,      IDX_HOLD, C_ALWAYS,  P_EMIT);
			5'd17: w = mk(OP_STEP,     IDX_INC,  C_NONE,    P_IDLE);
			5'd18: w = mk(OP_STEP,     IDX_HOLD, C_ALWAYS,  P_EMIT);
			5'd19: begin
				w = mk(OP_NOP, IDX_HOLD, C_ALWAYS, P_IDLE);
				w.emit = 1'b1;
			end
			5'd20: w = mk(OP_RES_ILL,  IDX_HOLD, C_ALWAYS,  P_EMIT);
			5'd21: w = mk(OP_NOP,      IDX_HOLD, C_BADSLOT, P_BAD);
			5'd22: w = mk(OP_NOP,      IDX_HOLD, C_SETMID,  P_SMID);
			5'd23: w = mk(OP_RES_ZERO, IDX_LAST, C_NONE,    P_IDLE);
			5'd24: w = mk(OP_WRP,      IDX_INC,  C_NONE,    P_IDLE);
			5'd25: w = mk(OP_WRP,      IDX_HOLD, C_ALWAYS,  P_EMIT);
			5'd26: w = mk(OP_RES_ZERO, IDX_SLOT, C_NONE,    P_IDLE);
			5'd27: w = mk(OP_WRP,      IDX_HOLD, C_ALWAYS,  P_EMIT);
			5'd28: w = mk(OP_RES_BAD,  IDX_HOLD, C_ALWAYS,  P_EMIT);
			default: w = mk(OP_NOP,    IDX_HOLD, C_ALWAYS,  P_IDLE);
		endcase
		return w;
	endfunction

	// Wiring number of a slot; slots past the eighth use wiring 0.
	function automatic logic [3:0] sel_wiring(input logic [31:0] sel, input logic [3:0] s);
		logic [3:0] w;
		w = 4'd0;
		if (s < 4'd8) begin
			w = sel[{s[2:0], 2'b00} +: 4];
		end
		if (w > 4'd9) begin
			w = 4'd9;
		end
		return w;
	endfunction

	function automatic logic [5:0] wire_fwd(input logic [3:0] w, input logic [5:0] t);
		return WIRING[w][t];
	endfunction

	// Inverse wiring: parallel match over the row.
	function automatic logic [5:0] wire_inv(input logic [3:0] w, input logic [5:0] v);
		logic [5:0] r;
		r = 6'd0;
		for (int k = 0; k < NSYM; k++) begin
			if (WIRING[w][k] == v) begin
				r = 6'(k);
			end
		end
		return r;
	endfunction

	function automatic logic [5:0] add40(input logic [5:0] a, input logic [5:0] b);
		logic [6:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 7'(NSYM)) begin
			s = s - 7'(NSYM);
		end
		return s[5:0];
	endfunction

	function automatic logic [5:0] sub40(input logic [5:0] a, input logic [5:0] b);
		logic [5:0] d;
		if (a >= b) begin
			d = a - b;
		end else begin
			d = a + 6'(NSYM) - b;
		end
		return d;
	endfunction

	// Symbol code of an ASCII character; bit 6 flags an illegal character.
	function automatic logic [6:0] char_code(input logic [7:0] c);
		logic [7:0] l;
		logic [6:0] r;
		l = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			l = c + 8'h20;
		end
		if (l >= 8'h61 && l <= 8'h7A) begin
			r = {1'b0, 6'(l - 8'h61)};
		end else if (l >= 8'h30 && l <= 8'h39) begin
			r = {1'b0, 6'(l - 8'h30 + 8'd26)};
		end else if (l == 8'h2C) begin
			r = {1'b0, 6'd36};
		end else if (l == 8'h2E) begin
			r = {1'b0, 6'd37};
		end else if (l == 8'h3F) begin
			r = {1'b0, 6'd38};
		end else if (l == 8'h20) begin
			r = {1'b0, 6'd39};
		end else begin
			r = {1'b1, 6'd0};
		end
		return r;
	endfunction

	// ASCII character of a symbol code.
	function automatic logic [7:0] code_char(input logic [5:0] t);
		logic [7:0] c;
		if (t < 6'd26) begin
			c = 8'h61 + 8'(t);
		end else if (t < 6'd36) begin
			c = 8'h30 + 8'(t - 6'd26);
		end else if (t == 6'd36) begin
			c = 8'h2C;
		end else if (t == 6'd37) begin
			c = 8'h2E;
		end else if (t == 6'd38) begin
			c = 8'h3F;
		end else begin
			c = 8'h20;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rotor_cipher_40_symbol.sv =====
`default_nettype none

// Rotor cipher over a 40-symbol alphabet, driven by a small microcode program.
// Input words arrive on s_*: s_tuser selects the command (0 encipher char_in,
// 1 set one rotor position), s_tdata carries char_in, slot and position_value.
// Each input word yields exactly one output word on m_*: the enciphered
// character and a status (0 ok, 1 illegal character, 2 slot out of range).
// The configuration port writes rotor_count (index 0) or rotor_select
// (index 1) whenever cfg_we is high; write it only while idle.
// With n rotors in use, the time an encipher takes from acceptance to
// m_tvalid depends on how far the stepping carry ripples. A set command
// writes one position, or both the last rotor and the reflector when it
// addresses either of them. The next word is accepted in the cycle after
// the result is loaded into the output register. The sequencer performs
// one rotor lookup or one position update per step over a single read
// port of the position registers.
// The output register lets a new word be accepted while a result waits; if
// the receiver stalls, the sequencer holds at its emit step until the output
// register is free. Reset clears all rotor positions to zero and restores the
// default configuration; s_tready is already high while reset is applied.
module rotor_cipher_40_symbol #(
	parameter int unsigned MAX_ROTORS = rc40_pkg::MAX_ROTORS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // char_in[7:0], slot[11:8], position_value[17:12]
	input  wire logic        s_tuser,   // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // char_out[7:0], status[9:8]
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int unsigned POS_DEPTH = MAX_ROTORS + 1;
	localparam int unsigned IDX_W     = $clog2(POS_DEPTH);
	localparam logic [3:0]  MAX_N     = 4'(MAX_ROTORS);

	// Control state.
	rc40_pkg::pc_t   pc_q;
	rc40_pkg::ctrl_t cw;
	logic [IDX_W-1:0] idx_q;
	logic             go_q;
	logic             out_valid_q;

	// Configuration.
	logic [3:0]  count_q;
	logic [31:0] select_q;

	// Latched command and working registers.
	logic       func_q;
	logic [7:0] char_q;
	logic [3:0] slot_q;
	logic [5:0] pval_q;
	logic [5:0] t_q;
	logic [7:0] res_char_q;
	logic [1:0] res_stat_q;
	logic [7:0] out_char_q;
	logic [1:0] out_stat_q;

	logic [5:0] pos_q [POS_DEPTH];

	logic             in_fire;
	logic             can_emit;
	logic             cond_ok;
	logic [3:0]       n_eff;
	logic [3:0]       n_m1;
	logic [3:0]       idx4;
	logic [IDX_W-1:0] rd_addr;
	logic [5:0]       pos_rd;
	logic [3:0]       wsel;
	logic [6:0]       code;
	logic [5:0]       t_d;
	logic             chk_d;
	logic [5:0]       pval_in;

	assign cw       = rc40_pkg::ucode(pc_q);
	assign s_tready = cw.wait_in;
	assign in_fire  = s_tvalid & s_tready;
	assign can_emit = ~out_valid_q | m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_stat_q, out_char_q};

	// Effective rotor count: zero acts as one, the top is clamped.
	always_comb begin
		n_eff = count_q;
		if (n_eff == 4'd0) begin
			n_eff = 4'd1;
		end
		if (n_eff > MAX_N) begin
			n_eff = MAX_N;
		end
	end

	assign n_m1 = n_eff - 4'd1;
	assign idx4 = 4'(idx_q);

	// Single read port on the position registers.
	assign rd_addr = (cw.op == rc40_pkg::OP_CHK) ? idx_q + IDX_W'(1) : idx_q;
	assign pos_rd  = pos_q[rd_addr];
	assign wsel    = rc40_pkg::sel_wiring(select_q, 4'(rd_addr));
	assign code    = rc40_pkg::char_code(char_q);

	// New position taken mod 40 at acceptance.
	assign pval_in = (s_tdata[17:12] >= 6'(rc40_pkg::NSYM)) ?
	                 s_tdata[17:12] - 6'(rc40_pkg::NSYM) : s_tdata[17:12];

	// Jump condition.
	always_comb begin
		unique case (cw.cond)
			rc40_pkg::C_NONE:    cond_ok = 1'b0;
			rc40_pkg::C_ALWAYS:  cond_ok = 1'b1;
			rc40_pkg::C_SET:     cond_ok = (func_q == rc40_pkg::FUNC_SET);
			rc40_pkg::C_ILLEGAL: cond_ok = code[6];
			rc40_pkg::C_LAST:    cond_ok = (idx4 == n_m1);
			rc40_pkg::C_NOTLAST: cond_ok = (idx4 != n_m1);
			rc40_pkg::C_ZERO:    cond_ok = (idx_q == '0);
			rc40_pkg::C_NOTZERO: cond_ok = (idx_q != '0);
			rc40_pkg::C_GO:      cond_ok = go_q;
			rc40_pkg::C_BADSLOT: cond_ok = ({1'b0, slot_q} > {1'b0, n_eff});
			rc40_pkg::C_SETMID:  cond_ok = ({1'b0, slot_q} + 5'd1 < {1'b0, n_eff});
			default:             cond_ok = 1'b0;
		endcase
	end

	// Symbol datapath.
	always_comb begin
		t_d   = t_q;
		chk_d = rc40_pkg::NOTCH[wsel] == pos_rd;
		case (cw.op)
			rc40_pkg::OP_LOAD:   t_d = code[5:0];
			rc40_pkg::OP_ADDP:   t_d = rc40_pkg::add40(t_q, pos_rd);
			rc40_pkg::OP_FWDSUB: t_d = rc40_pkg::sub40(rc40_pkg::wire_fwd(wsel, t_q), pos_rd);
			rc40_pkg::OP_INVSUB: t_d = rc40_pkg::sub40(rc40_pkg::wire_inv(wsel, t_q), pos_rd);
			rc40_pkg::OP_FWDREF: t_d = rc40_pkg::REFLECTOR[rc40_pkg::wire_fwd(wsel, t_q)];
			default:             t_d = t_q;
		endcase
	end

	// Program counter, slot index and stepping carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= rc40_pkg::P_IDLE;
			idx_q <= '0;
			go_q  <= 1'b0;
		end else begin
			if (cw.wait_in) begin
				if (in_fire) begin
					pc_q <= pc_q + rc40_pkg::PC_W'(1);
				end
			end else if (cw.emit) begin
				if (can_emit) begin
					pc_q <= cw.target;
				end
			end else if (cond_ok) begin
				pc_q <= cw.target;
			end else begin
				pc_q <= pc_q + rc40_pkg::PC_W'(1);
			end
			case (cw.idx_act)
				rc40_pkg::IDX_CLR:  idx_q <= '0;
				rc40_pkg::IDX_INC:  idx_q <= idx_q + IDX_W'(1);
				rc40_pkg::IDX_DEC:  idx_q <= idx_q - IDX_W'(1);
				rc40_pkg::IDX_LAST: idx_q <= IDX_W'(n_m1);
				rc40_pkg::IDX_SLOT: idx_q <= IDX_W'(slot_q);
				default:            idx_q <= idx_q;
			endcase
			if (cw.op == rc40_pkg::OP_CHK) begin
				go_q <= chk_d;
			end
		end
	end

	// Rotor positions: one write per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POS_DEPTH; i++) begin
				pos_q[i] <= 6'd0;
			end
		end else if (cw.op == rc40_pkg::OP_STEP) begin
			pos_q[idx_q] <= rc40_pkg::add40(pos_rd, 6'd1);
		end else if (cw.op == rc40_pkg::OP_WRP) begin
			pos_q[idx_q] <= pval_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= rc40_pkg::COUNT_RESET;
			select_q <= rc40_pkg::SELECT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rc40_pkg::CFG_ROTOR_COUNT:  count_q  <= cfg_data[3:0];
				rc40_pkg::CFG_ROTOR_SELECT: select_q <= cfg_data;
				default:                    count_q  <= count_q;
			endcase
		end
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.emit && can_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= s_tuser;
			char_q <= s_tdata[7:0];
			slot_q <= s_tdata[11:8];
			pval_q <= pval_in;
		end
		t_q <= t_d;
		case (cw.op)
			rc40_pkg::OP_RES_OK: begin
				res_char_q <= rc40_pkg::code_char(t_q);
				res_stat_q <= rc40_pkg::ST_OK;
			end
			rc40_pkg::OP_RES_ZERO: begin
				res_char_q <= 8'd0;
				res_stat_q <= rc40_pkg::ST_OK;
			end
			rc40_pkg::OP_RES_ILL: begin
				res_char_q <= 8'd0;
				res_stat_q <= rc40_pkg::ST_ILLEGAL;
			end
			rc40_pkg::OP_RES_BAD: begin
				res_char_q <= 8'd0;
				res_stat_q <= rc40_pkg::ST_BAD_SLOT;
			end
			default: begin
				res_char_q <= res_char_q;
				res_stat_q <= res_stat_q;
			end
		endcase
		if (cw.emit && can_emit) begin
			out_char_q <= res_char_q;
			out_stat_q <= res_stat_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rc40_checker.sv =====
`default_nettype none

module rc40_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// A stalled output word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// The status field only carries defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:8] != 2'd3)
		else $error("undefined status code");

	// Any error status comes with a zero character.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9:8] != 2'd0 |-> m_tdata[7:0] == 8'd0)
		else $error("error result carries a character");

	// One word at a time: the input closes right after an accept.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a word is in progress");

endmodule

bind rotor_cipher_40_symbol rc40_checker u_rc40_checker (.*);

`default_nettype wire
